FILE: src/gafs_pkg.sv
// Shared codes, field widths and control bundles of the grid path step engine.
`default_nettype none
package gafs_pkg;

    localparam int COORD_W    = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 2;

    localparam logic [CFG_DATA_W-1:0] GRID_RESET = 7'd64;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_H = 2'd1;

    localparam logic [1:0] DIR_PX = 2'd0;
    localparam logic [1:0] DIR_MX = 2'd1;
    localparam logic [1:0] DIR_PY = 2'd2;
    localparam logic [1:0] DIR_MY = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_heap_ctl;

    typedef struct packed {
        logic busy;
        logic empty;
    } t_heap_sts;

    typedef struct packed {
        logic blk_we;
        logic blk_bit;
        logic node_we;
    } t_cell_we;

endpackage
`default_nettype wire

FILE: src/grid_astar_first_step.sv
// Top level: A* first-step engine over a blocked-cell grid, with search sequencer.
//
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+---------------------------------
//  in       | i_in_valid / o_in_ready, command + coords | one map write or one path query
//  out      | o_out_valid / i_out_ready, step + found   | one result per query
//  cfg      | i_cfg_valid / o_cfg_ready, index + data   | one register write, always taken
//
//  Map write: done in the cycle it is taken. Query: one clearing sweep over the node store,
//  then each cell popped from the heap is expanded and each open neighbor with a lower cost
//  is pushed; then a walk back along parent links from the target to the start.
//  Bad or trivial queries skip the search. The heap memory port sets the expansion rate.
//  Reset: the map and node store are swept with o_in_ready low.
//  A finished result waits in the output register; the next item is taken meanwhile.
`default_nettype none
module grid_astar_first_step #(
    parameter int MAX_SIDE   = 64,
    parameter int OPEN_DEPTH = 16384
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_command,
    input  wire logic [gafs_pkg::COORD_W-1:0]        i_cell_x,
    input  wire logic [gafs_pkg::COORD_W-1:0]        i_cell_y,
    input  wire logic                                i_cell_blocked,
    input  wire logic [gafs_pkg::COORD_W-1:0]        i_from_x,
    input  wire logic [gafs_pkg::COORD_W-1:0]        i_from_y,
    input  wire logic [gafs_pkg::COORD_W-1:0]        i_to_x,
    input  wire logic [gafs_pkg::COORD_W-1:0]        i_to_y,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [gafs_pkg::STEP_W-1:0]       o_step_dx,
    output logic signed [gafs_pkg::STEP_W-1:0]       o_step_dy,
    output logic                                     o_path_found,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gafs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [gafs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gafs_pkg::*;

    localparam int XW = $clog2(MAX_SIDE);
    localparam int AW = 2 * XW;
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int QW = (XW + 1 > 7) ? XW + 1 : 7;
    localparam int KW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int GW = KW + 1;
    localparam int FW = KW + 2;
    localparam int DW = XW + 1;
    localparam int EW = FW + KW + 2 * XW;
    localparam int OW = FW + KW;
    localparam int NW = GW + 4;

    typedef struct packed {
        logic          done;
        logic          reached;
        logic [GW-1:0] cost;
        logic [1:0]    pdir;
    } t_node;

    typedef enum logic [13:0] {
        S_INIT      = 14'b00000000000001,
        S_IDLE      = 14'b00000000000010,
        S_CLEAR     = 14'b00000000000100,
        S_SEED      = 14'b00000000001000,
        S_SEED_W    = 14'b00000000010000,
        S_POP       = 14'b00000000100000,
        S_POP_WAIT  = 14'b00000001000000,
        S_TOP_CHK   = 14'b00000010000000,
        S_NB_RD     = 14'b00000100000000,
        S_NB_CHK    = 14'b00001000000000,
        S_PUSH_WAIT = 14'b00010000000000,
        S_WALK_RD   = 14'b00100000000000,
        S_WALK_CHK  = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } t_state;

    t_state                 r_state, n_state;
    logic [CFG_DATA_W-1:0]  r_grid_w, r_grid_h;
    logic [AW-1:0]          r_sweep, n_sweep;
    logic [SW-1:0]          r_w, n_w, r_h, n_h, w_w_eff, w_h_eff;
    logic [XW-1:0]          r_sx, n_sx, r_sy, n_sy, r_tx, n_tx, r_ty, n_ty;
    logic [XW-1:0]          r_cx, n_cx, r_cy, n_cy, r_nx, n_nx, r_ny, n_ny;
    logic [XW-1:0]          r_wx, n_wx, r_wy, n_wy;
    logic [GW-1:0]          r_g, n_g;
    logic [KW-1:0]          r_nkey, n_nkey;
    logic [DW-1:0]          r_nh, n_nh;
    logic [1:0]             r_dir, n_dir;
    logic                   r_res_found, n_res_found;
    logic [1:0]             r_res_dx, n_res_dx, r_res_dy, n_res_dy;
    logic                   r_out_valid, n_out_valid;
    logic [1:0]             r_dx, r_dy;
    logic                   r_found;
    logic                   w_load;

    t_heap_ctl              w_hctl;
    t_heap_sts              w_hsts;
    logic [EW-1:0]          w_hentry, w_htop;
    t_cell_we               w_cwe;
    logic [AW-1:0]          w_blk_waddr, w_node_waddr, w_raddr;
    t_node                  w_node_wdata, w_node;
    logic [NW-1:0]          w_node_rdata;
    logic                   w_blk_rdata;

    logic [DW-1:0]          w_nx_e, w_ny_e;
    logic                   w_under, w_nb_ok;
    logic [XW-1:0]          w_nx, w_ny, w_kx, w_ky, w_ax, w_ay, w_px, w_py;
    logic [XW-1:0]          w_top_x, w_top_y;
    logic [XW+SW-1:0]       w_prod;
    logic [KW-1:0]          w_key;
    logic [DW-1:0]          w_h;
    logic [GW-1:0]          w_ng;
    logic [FW-1:0]          w_f;
    logic [DW-1:0]          w_ddx, w_ddy;
    logic                   w_q_bad, w_wr_ok;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= GRID_RESET;
            r_grid_h <= GRID_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_W: r_grid_w <= i_cfg_data;
                CFG_GRID_H: r_grid_h <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_grid_w == '0) begin
            w_w_eff = SW'(1);
        end else if (QW'(r_grid_w) > QW'(MAX_SIDE)) begin
            w_w_eff = SW'(MAX_SIDE);
        end else begin
            w_w_eff = SW'(r_grid_w);
        end
        if (r_grid_h == '0) begin
            w_h_eff = SW'(1);
        end else if (QW'(r_grid_h) > QW'(MAX_SIDE)) begin
            w_h_eff = SW'(MAX_SIDE);
        end else begin
            w_h_eff = SW'(r_grid_h);
        end
    end

    assign w_q_bad = (QW'(i_from_x) >= QW'(w_w_eff)) || (QW'(i_from_y) >= QW'(w_h_eff))
                  || (QW'(i_to_x) >= QW'(w_w_eff)) || (QW'(i_to_y) >= QW'(w_h_eff))
                  || ((i_from_x == i_to_x) && (i_from_y == i_to_y));
    assign w_wr_ok = (QW'(i_cell_x) < QW'(MAX_SIDE)) && (QW'(i_cell_y) < QW'(MAX_SIDE));

    // neighbor coordinates
    always_comb begin
        w_nx_e  = {1'b0, r_cx};
        w_ny_e  = {1'b0, r_cy};
        w_under = 1'b0;
        unique case (r_dir)
            DIR_PX: w_nx_e = {1'b0, r_cx} + 1'b1;
            DIR_MX: begin
                w_nx_e  = {1'b0, r_cx} - 1'b1;
                w_under = (r_cx == '0);
            end
            DIR_PY: w_ny_e = {1'b0, r_cy} + 1'b1;
            DIR_MY: begin
                w_ny_e  = {1'b0, r_cy} - 1'b1;
                w_under = (r_cy == '0);
            end
            default: ;
        endcase
    end
    assign w_nb_ok = !w_under && (QW'(w_nx_e) < QW'(r_w)) && (QW'(w_ny_e) < QW'(r_h));
    assign w_nx    = w_nx_e[XW-1:0];
    assign w_ny    = w_ny_e[XW-1:0];

    // order key and heuristic
    assign w_kx   = (r_state == S_SEED) ? r_sx : w_nx;
    assign w_ky   = (r_state == S_SEED) ? r_sy : w_ny;
    assign w_prod = w_ky * r_w;
    assign w_key  = KW'(w_prod + (XW+SW)'(w_kx));
    assign w_ax   = (w_kx >= r_tx) ? (w_kx - r_tx) : (r_tx - w_kx);
    assign w_ay   = (w_ky >= r_ty) ? (w_ky - r_ty) : (r_ty - w_ky);
    assign w_h    = DW'(w_ax) + DW'(w_ay);

    assign w_ng   = r_g + 1'b1;
    assign w_f    = FW'(w_ng) + FW'(r_nh);
    assign w_node = t_node'(w_node_rdata);

    assign w_top_x = w_htop[2*XW-1:XW];
    assign w_top_y = w_htop[XW-1:0];

    // parent of the walked cell
    always_comb begin
        w_px = r_wx;
        w_py = r_wy;
        unique case (w_node.pdir)
            DIR_PX:  w_px = r_wx - 1'b1;
            DIR_MX:  w_px = r_wx + 1'b1;
            DIR_PY:  w_py = r_wy - 1'b1;
            DIR_MY:  w_py = r_wy + 1'b1;
            default: ;
        endcase
    end
    assign w_ddx = {1'b0, r_wx} - {1'b0, r_sx};
    assign w_ddy = {1'b0, r_wy} - {1'b0, r_sy};

    assign o_in_ready = (r_state == S_IDLE);
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_w          = r_w;
        n_h          = r_h;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_tx         = r_tx;
        n_ty         = r_ty;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_nx         = r_nx;
        n_ny         = r_ny;
        n_wx         = r_wx;
        n_wy         = r_wy;
        n_g          = r_g;
        n_nkey       = r_nkey;
        n_nh         = r_nh;
        n_dir        = r_dir;
        n_res_found  = r_res_found;
        n_res_dx     = r_res_dx;
        n_res_dy     = r_res_dy;
        w_hctl       = '0;
        w_hentry     = {FW'(r_nh), r_nkey, r_nx, r_ny};
        w_cwe        = '0;
        w_blk_waddr  = {XW'(i_cell_y), XW'(i_cell_x)};
        w_node_waddr = {r_ny, r_nx};
        w_node_wdata = '0;
        w_raddr      = {w_ny, w_nx};
        unique case (r_state)
            S_INIT: begin
                w_cwe.blk_we  = 1'b1;
                w_cwe.node_we = 1'b1;
                w_blk_waddr   = r_sweep;
                w_node_waddr  = r_sweep;
                n_sweep       = r_sweep + 1'b1;
                if (r_sweep == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_WRITE) begin
                        w_cwe.blk_we  = w_wr_ok;
                        w_cwe.blk_bit = i_cell_blocked;
                    end else begin
                        n_w          = w_w_eff;
                        n_h          = w_h_eff;
                        n_sx         = XW'(i_from_x);
                        n_sy         = XW'(i_from_y);
                        n_tx         = XW'(i_to_x);
                        n_ty         = XW'(i_to_y);
                        n_sweep      = '0;
                        n_res_found  = 1'b0;
                        n_res_dx     = '0;
                        n_res_dy     = '0;
                        w_hctl.clear = 1'b1;
                        n_state      = w_q_bad ? S_DONE : S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                w_cwe.node_we = 1'b1;
                w_node_waddr  = r_sweep;
                n_sweep       = r_sweep + 1'b1;
                if (r_sweep == '1) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                n_nkey  = w_key;
                n_nh    = w_h;
                n_state = S_SEED_W;
            end
            S_SEED_W: begin
                w_cwe.node_we        = 1'b1;
                w_node_waddr         = {r_sy, r_sx};
                w_node_wdata.reached = 1'b1;
                w_hctl.push          = 1'b1;
                w_hentry             = {FW'(r_nh), r_nkey, r_sx, r_sy};
                n_dir                = DIR_MY;
                n_state              = S_PUSH_WAIT;
            end
            S_POP: begin
                if (w_hsts.empty) begin
                    n_state = S_DONE;
                end else begin
                    w_hctl.pop = 1'b1;
                    n_state    = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                w_raddr = {w_top_y, w_top_x};
                if (!w_hsts.busy) begin
                    n_cx    = w_top_x;
                    n_cy    = w_top_y;
                    n_state = S_TOP_CHK;
                end
            end
            S_TOP_CHK: begin
                if (w_node.done) begin
                    n_state = S_POP;
                end else begin
                    w_cwe.node_we     = 1'b1;
                    w_node_waddr      = {r_cy, r_cx};
                    w_node_wdata      = w_node;
                    w_node_wdata.done = 1'b1;
                    n_g               = w_node.cost;
                    if (r_cx == r_tx && r_cy == r_ty) begin
                        n_wx    = r_tx;
                        n_wy    = r_ty;
                        n_state = S_WALK_RD;
                    end else begin
                        n_dir   = DIR_PX;
                        n_state = S_NB_RD;
                    end
                end
            end
            S_NB_RD: begin
                if (w_nb_ok) begin
                    n_nx    = w_nx;
                    n_ny    = w_ny;
                    n_nkey  = w_key;
                    n_nh    = w_h;
                    n_state = S_NB_CHK;
                end else if (r_dir == DIR_MY) begin
                    n_state = S_POP;
                end else begin
                    n_dir = r_dir + 1'b1;
                end
            end
            S_NB_CHK: begin
                if ((w_blk_rdata && !(r_nx == r_tx && r_ny == r_ty))
                        || (w_node.reached && !(w_ng < w_node.cost))) begin
                    if (r_dir == DIR_MY) begin
                        n_state = S_POP;
                    end else begin
                        n_dir   = r_dir + 1'b1;
                        n_state = S_NB_RD;
                    end
                end else begin
                    w_cwe.node_we        = 1'b1;
                    w_node_wdata.done    = w_node.done;
                    w_node_wdata.reached = 1'b1;
                    w_node_wdata.cost    = w_ng;
                    w_node_wdata.pdir    = r_dir;
                    w_hctl.push          = 1'b1;
                    w_hentry             = {w_f, r_nkey, r_nx, r_ny};
                    n_state              = S_PUSH_WAIT;
                end
            end
            S_PUSH_WAIT: begin
                if (!w_hsts.busy) begin
                    if (r_dir == DIR_MY) begin
                        n_state = S_POP;
                    end else begin
                        n_dir   = r_dir + 1'b1;
                        n_state = S_NB_RD;
                    end
                end
            end
            S_WALK_RD: begin
                w_raddr = {r_wy, r_wx};
                n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (w_px == r_sx && w_py == r_sy) begin
                    n_res_found = 1'b1;
                    n_res_dx    = w_ddx[1:0];
                    n_res_dy    = w_ddy[1:0];
                    n_state     = S_DONE;
                end else begin
                    n_wx    = w_px;
                    n_wy    = w_py;
                    n_state = S_WALK_RD;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w         <= n_w;
        r_h         <= n_h;
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_tx        <= n_tx;
        r_ty        <= n_ty;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_nx        <= n_nx;
        r_ny        <= n_ny;
        r_wx        <= n_wx;
        r_wy        <= n_wy;
        r_g         <= n_g;
        r_nkey      <= n_nkey;
        r_nh        <= n_nh;
        r_dir       <= n_dir;
        r_res_found <= n_res_found;
        r_res_dx    <= n_res_dx;
        r_res_dy    <= n_res_dy;
        if (w_load) begin
            r_dx    <= r_res_dx;
            r_dy    <= r_res_dy;
            r_found <= r_res_found;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_step_dx    = r_dx;
    assign o_step_dy    = r_dy;
    assign o_path_found = r_found;

    gafs_cell_store #(
        .AW (AW),
        .NW (NW)
    ) u_cells (
        .i_clk        (i_clk),
        .i_we         (w_cwe),
        .i_blk_waddr  (w_blk_waddr),
        .i_node_waddr (w_node_waddr),
        .i_node_wdata (w_node_wdata),
        .i_raddr      (w_raddr),
        .o_blk_rdata  (w_blk_rdata),
        .o_node_rdata (w_node_rdata)
    );

    gafs_open_heap #(
        .DEPTH (OPEN_DEPTH),
        .EW    (EW),
        .OW    (OW)
    ) u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_hctl),
        .i_entry (w_hentry),
        .o_sts   (w_hsts),
        .o_top   (w_htop)
    );

    a_found_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_path_found |-> $countones({o_step_dx != 2'sd0, o_step_dy != 2'sd0}) == 1)
        else $error("found step is not a single unit move");

    a_nofound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_path_found |-> o_step_dx == 2'sd0 && o_step_dy == 2'sd0)
        else $error("no-path result carries a move");

    a_heap_idle_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hctl.push || w_hctl.pop) |-> !w_hsts.busy)
        else $error("heap command while heap busy");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hctl.pop |-> !w_hsts.empty)
        else $error("pop from empty open set");

endmodule
`default_nettype wire

FILE: src/gafs_cell_store.sv
// Per-cell storage: blocked bitmap and search node words, one shared read address.
`default_nettype none
module gafs_cell_store #(
    parameter int AW = 12,
    parameter int NW = 18
) (
    input  wire logic                 i_clk,
    input  wire gafs_pkg::t_cell_we   i_we,
    input  wire logic [AW-1:0]        i_blk_waddr,
    input  wire logic [AW-1:0]        i_node_waddr,
    input  wire logic [NW-1:0]        i_node_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic                      o_blk_rdata,
    output logic [NW-1:0]             o_node_rdata
);
    import gafs_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic            r_blk_mem  [DEPTH];
    logic [NW-1:0]   r_node_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.blk_we) begin
            r_blk_mem[i_blk_waddr] <= i_we.blk_bit;
        end
        o_blk_rdata <= r_blk_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.node_we) begin
            r_node_mem[i_node_waddr] <= i_node_wdata;
        end
        o_node_rdata <= r_node_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/gafs_open_heap.sv
// Open set: binary min-heap in a one-write two-read memory with sift sequencer.
`default_nettype none
module gafs_open_heap #(
    parameter int DEPTH = 16384,
    parameter int EW    = 40,
    parameter int OW    = 28
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gafs_pkg::t_heap_ctl  i_ctl,
    input  wire logic [EW-1:0]        i_entry,
    output gafs_pkg::t_heap_sts       o_sts,
    output logic [EW-1:0]             o_top
);
    import gafs_pkg::*;

    localparam int HW = $clog2(DEPTH);
    localparam int LW = HW + 1;
    localparam int CW = HW + 2;

    typedef enum logic [4:0] {
        H_IDLE     = 5'b00001,
        H_PUSH_CMP = 5'b00010,
        H_PUSH_FIN = 5'b00100,
        H_POP_LD   = 5'b01000,
        H_POP_CMP  = 5'b10000
    } t_hstate;

    t_hstate         r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic [HW-1:0]   r_idx, n_idx;
    logic [EW-1:0]   r_entry, n_entry;
    logic [EW-1:0]   r_top, n_top;
    logic [EW-1:0]   r_rd0, r_rd1;
    logic [EW-1:0]   r_heap_mem [DEPTH];

    logic            w_we;
    logic [HW-1:0]   w_waddr, w_ra0, w_ra1;
    logic [EW-1:0]   w_wdata, w_best;
    logic [HW-1:0]   w_par_idx;
    logic [CW-1:0]   w_ch_l, w_ch_r, w_sel;
    logic [CW-1:0]   w_gc_l, w_gc_r;
    logic            w_moved;

    function automatic logic less(input logic [EW-1:0] a, input logic [EW-1:0] b);
        return a[EW-1 -: OW] < b[EW-1 -: OW];
    endfunction

    assign w_par_idx = HW'((r_idx - 1'b1) >> 1);
    assign w_ch_l    = {1'b0, r_idx, 1'b1};
    assign w_ch_r    = {1'b0, r_idx, 1'b0} + CW'(2);

    always_comb begin
        w_best  = r_entry;
        w_sel   = w_ch_l;
        w_moved = 1'b0;
        if (w_ch_l < CW'(r_len) && less(r_rd0, w_best)) begin
            w_best  = r_rd0;
            w_sel   = w_ch_l;
            w_moved = 1'b1;
        end
        if (w_ch_r < CW'(r_len) && less(r_rd1, w_best)) begin
            w_best  = r_rd1;
            w_sel   = w_ch_r;
            w_moved = 1'b1;
        end
    end

    assign w_gc_l = {w_sel[CW-2:0], 1'b1};
    assign w_gc_r = {w_sel[CW-2:0], 1'b0} + CW'(2);

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_idx   = r_idx;
        n_entry = r_entry;
        n_top   = r_top;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_entry;
        w_ra0   = '0;
        w_ra1   = '0;
        unique case (r_state)
            H_IDLE: begin
                if (i_ctl.clear) begin
                    n_len = '0;
                end else if (i_ctl.push) begin
                    if (r_len == LW'(DEPTH)) begin
                        n_len = r_len;
                    end else if (r_len == '0) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        w_wdata = i_entry;
                        n_len   = LW'(1);
                    end else begin
                        n_idx   = HW'(r_len);
                        n_len   = r_len + 1'b1;
                        n_entry = i_entry;
                        w_ra0   = HW'((r_len - 1'b1) >> 1);
                        n_state = H_PUSH_CMP;
                    end
                end else if (i_ctl.pop) begin
                    w_ra0   = '0;
                    w_ra1   = HW'(r_len - 1'b1);
                    n_len   = r_len - 1'b1;
                    n_state = H_POP_LD;
                end
            end
            H_PUSH_CMP: begin
                w_we = 1'b1;
                if (less(r_entry, r_rd0)) begin
                    w_wdata = r_rd0;
                    n_idx   = w_par_idx;
                    w_ra0   = HW'((w_par_idx - 1'b1) >> 1);
                    if (w_par_idx == '0) begin
                        n_state = H_PUSH_FIN;
                    end
                end else begin
                    n_state = H_IDLE;
                end
            end
            H_PUSH_FIN: begin
                w_we    = 1'b1;
                n_state = H_IDLE;
            end
            H_POP_LD: begin
                n_top   = r_rd0;
                n_entry = r_rd1;
                n_idx   = '0;
                w_ra0   = HW'(1);
                w_ra1   = HW'(2);
                n_state = (r_len == '0) ? H_IDLE : H_POP_CMP;
            end
            H_POP_CMP: begin
                w_we = 1'b1;
                if (w_moved) begin
                    w_wdata = w_best;
                    n_idx   = w_sel[HW-1:0];
                    w_ra0   = w_gc_l[HW-1:0];
                    w_ra1   = w_gc_r[HW-1:0];
                end else begin
                    n_state = H_IDLE;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_entry <= n_entry;
        r_top   <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_heap_mem[w_waddr] <= w_wdata;
        end
        r_rd0 <= r_heap_mem[w_ra0];
        r_rd1 <= r_heap_mem[w_ra1];
    end

    assign o_sts.busy  = (r_state != H_IDLE);
    assign o_sts.empty = (r_len == '0);
    assign o_top       = r_top;

endmodule
`default_nettype wire
